### rtl/tkrc_pkg.sv
// Shared types and constants for the keyed result cache.
package tkrc_pkg;

   localparam int KEY_W           = 40;
   localparam int TIME_W          = 32;
   localparam int WORD_W          = 32;
   localparam int CODE_W          = 4;
   localparam int SLOT_W          = 3;
   localparam int TTL_W           = 16;
   localparam int ENTRIES_DEFAULT = 8;

   localparam logic [TTL_W-1:0] TTL_RESET = 16'd300;

   // action codes
   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_STORE  = 1'b1;

   // request beat
   typedef struct packed {
      logic              action;
      logic [KEY_W-1:0]  account_key;
      logic [TIME_W-1:0] now_seconds;
      logic              entitled;
      logic [WORD_W-1:0] result_word;
      logic [CODE_W-1:0] result_code;
   } req_type;

   // response beat
   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic [WORD_W-1:0] payload_out;
      logic [CODE_W-1:0] code_out;
      logic              stored;
      logic              evicted_live;
   } rsp_type;

   // search record handed from cell to cell (slot indexes travel beside it)
   typedef struct packed {
      logic              valid;
      logic              live;
      logic              inv;
      logic              min_set;
      logic [TIME_W-1:0] min_exp;
      logic [WORD_W-1:0] payload;
      logic [CODE_W-1:0] code;
   } srch_type;

   // entry write broadcast to all cells (target slot travels beside it)
   typedef struct packed {
      logic              en;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] expiry;
      logic [WORD_W-1:0] payload;
      logic [CODE_W-1:0] code;
   } wr_type;

endpackage

### rtl/tkrc_cell.sv
// One cache entry plus one registered stage of the search chain.
module tkrc_cell #(
   parameter int ENTRIES = tkrc_pkg::ENTRIES_DEFAULT,
   parameter int INDEX   = 0,
   localparam int IDX_W  = $clog2(ENTRIES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tkrc_pkg::KEY_W-1:0]    key,
   input  logic [tkrc_pkg::TIME_W-1:0]   now,
   input  tkrc_pkg::wr_type              wr,
   input  logic [IDX_W-1:0]              wr_idx,
   input  tkrc_pkg::srch_type            s_in,
   input  logic [IDX_W-1:0]              live_idx_in,
   input  logic [IDX_W-1:0]              inv_idx_in,
   input  logic [IDX_W-1:0]              min_idx_in,
   output tkrc_pkg::srch_type            s_out,
   output logic [IDX_W-1:0]              live_idx_out,
   output logic [IDX_W-1:0]              inv_idx_out,
   output logic [IDX_W-1:0]              min_idx_out
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic                          valid_ff;
   logic [tkrc_pkg::KEY_W-1:0]    key_ff;
   logic [tkrc_pkg::TIME_W-1:0]   exp_ff;
   logic [tkrc_pkg::WORD_W-1:0]   pay_ff;
   logic [tkrc_pkg::CODE_W-1:0]   code_ff;

   tkrc_pkg::srch_type            s_ff, s_in_next;
   logic [IDX_W-1:0]              live_ff, live_in, inv_ff, inv_in, min_ff, min_in;
   logic                          match;

   // entry storage: valid bit resets, the rest is written on a store
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr.en && wr_idx == MY_IDX) begin
         valid_ff <= 1'b1;
      end
      if (wr.en && wr_idx == MY_IDX) begin
         key_ff  <= wr.key;
         exp_ff  <= wr.expiry;
         pay_ff  <= wr.payload;
         code_ff <= wr.code;
      end
   end

   // fold this entry into the passing search record
   assign match = valid_ff && (key_ff == key) && (exp_ff > now);

   always_comb begin
      s_in_next = s_in;
      live_in   = live_idx_in;
      inv_in    = inv_idx_in;
      min_in    = min_idx_in;
      // first live match wins
      if (!s_in.live && match) begin
         s_in_next.live    = 1'b1;
         s_in_next.payload = pay_ff;
         s_in_next.code    = code_ff;
         live_in           = MY_IDX;
      end
      // first free slot
      if (!s_in.inv && !valid_ff) begin
         s_in_next.inv = 1'b1;
         inv_in        = MY_IDX;
      end
      // earliest expiry, strict compare keeps the lower index on ties
      if (!s_in.min_set || exp_ff < s_in.min_exp) begin
         s_in_next.min_set = 1'b1;
         s_in_next.min_exp = exp_ff;
         min_in            = MY_IDX;
      end
   end

   // stage register toward the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff <= '0;
      end else begin
         s_ff <= s_in_next;
      end
      live_ff <= live_in;
      inv_ff  <= inv_in;
      min_ff  <= min_in;
   end

   assign s_out        = s_ff;
   assign live_idx_out = live_ff;
   assign inv_idx_out  = inv_ff;
   assign min_idx_out  = min_ff;

endmodule

### rtl/ttl_keyed_result_cache.sv
// The search record passes the launch register, each entry cell's stage register and
// the finish register, then the response register once the response slot is free.
// The record walks the cells one per cycle, with one request in flight at a time.
// A new request is taken while the previous response still waits to be taken.
// Reset (synchronous, active high) clears all entry valid bits and sets the TTL to 300.
module ttl_keyed_result_cache #(
   parameter int ENTRIES = tkrc_pkg::ENTRIES_DEFAULT,
   localparam int IDX_W  = $clog2(ENTRIES)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  tkrc_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output tkrc_pkg::rsp_type           rsp_data,
   input  logic                        csr_we,
   input  logic [tkrc_pkg::TTL_W-1:0]  csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   state_type                      state_ff, state_in;
   tkrc_pkg::req_type              hold_ff, hold_in;
   logic                           launch_ff, launch_in;
   tkrc_pkg::srch_type             fin_ff, fin_in;
   logic [IDX_W-1:0]               fin_live_ff, fin_live_in;
   logic [IDX_W-1:0]               fin_inv_ff, fin_inv_in;
   logic [IDX_W-1:0]               fin_min_ff, fin_min_in;
   logic [tkrc_pkg::TTL_W-1:0]     ttl_ff, ttl_in;
   tkrc_pkg::rsp_type              rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   tkrc_pkg::wr_type               wr_ff, wr_in;
   logic [IDX_W-1:0]               wr_idx_ff, wr_idx_in;

   // search chain wiring, index 0 is the head
   tkrc_pkg::srch_type             chain [0:ENTRIES];
   logic [IDX_W-1:0]               live_c [0:ENTRIES];
   logic [IDX_W-1:0]               inv_c  [0:ENTRIES];
   logic [IDX_W-1:0]               min_c  [0:ENTRIES];

   logic                           req_accept;
   logic                           rsp_free;
   logic                           do_store;
   logic [IDX_W-1:0]               sel_idx;
   logic [IDX_W+2:0]               sel_wide, live_wide;
   logic [tkrc_pkg::TIME_W:0]      exp_sum;
   logic [tkrc_pkg::TIME_W-1:0]    exp_sat;

   // head of the chain: an empty record marked valid for one cycle
   always_comb begin
      chain[0]       = '0;
      chain[0].valid = launch_ff;
      live_c[0]      = '0;
      inv_c[0]       = '0;
      min_c[0]       = '0;
   end

   // row of entry cells
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      tkrc_cell #(
         .ENTRIES (ENTRIES),
         .INDEX   (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .key          (hold_ff.account_key),
         .now          (hold_ff.now_seconds),
         .wr           (wr_ff),
         .wr_idx       (wr_idx_ff),
         .s_in         (chain[i]),
         .live_idx_in  (live_c[i]),
         .inv_idx_in   (inv_c[i]),
         .min_idx_in   (min_c[i]),
         .s_out        (chain[i+1]),
         .live_idx_out (live_c[i+1]),
         .inv_idx_out  (inv_c[i+1]),
         .min_idx_out  (min_c[i+1])
      );
   end

   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // store decision from the finished search record
   assign do_store  = (hold_ff.action == tkrc_pkg::ACT_STORE) && hold_ff.entitled;
   assign sel_idx   = fin_ff.live ? fin_live_ff : (fin_ff.inv ? fin_inv_ff : fin_min_ff);
   assign sel_wide  = (IDX_W+3)'(sel_idx);
   assign live_wide = (IDX_W+3)'(fin_live_ff);
   assign exp_sum   = {1'b0, hold_ff.now_seconds} + (tkrc_pkg::TIME_W+1)'(ttl_ff);
   assign exp_sat   = exp_sum[tkrc_pkg::TIME_W] ? '1 : exp_sum[tkrc_pkg::TIME_W-1:0];

   // controller next state
   always_comb begin
      state_in     = state_ff;
      hold_in      = hold_ff;
      launch_in    = 1'b0;
      fin_in       = fin_ff;
      fin_live_in  = fin_live_ff;
      fin_inv_in   = fin_inv_ff;
      fin_min_in   = fin_min_ff;
      ttl_in       = csr_we ? csr_wdata : ttl_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_in        = wr_ff;
      wr_in.en     = 1'b0;
      wr_idx_in    = wr_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               hold_in   = req_data;
               launch_in = 1'b1;
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // capture the record as it leaves the last cell
            if (chain[ENTRIES].valid) begin
               fin_in      = chain[ENTRIES];
               fin_live_in = live_c[ENTRIES];
               fin_inv_in  = inv_c[ENTRIES];
               fin_min_in  = min_c[ENTRIES];
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               if (hold_ff.action == tkrc_pkg::ACT_LOOKUP) begin
                  if (fin_ff.live) begin
                     rsp_in.hit         = 1'b1;
                     rsp_in.slot        = live_wide[2:0];
                     rsp_in.payload_out = fin_ff.payload;
                     rsp_in.code_out    = fin_ff.code;
                  end
               end else if (do_store) begin
                  rsp_in.stored       = 1'b1;
                  rsp_in.slot         = sel_wide[2:0];
                  rsp_in.evicted_live = !fin_ff.live && !fin_ff.inv;
                  wr_in.en            = 1'b1;
                  wr_in.key           = hold_ff.account_key;
                  wr_in.expiry        = exp_sat;
                  wr_in.payload       = hold_ff.result_word;
                  wr_in.code          = hold_ff.result_code;
                  wr_idx_in           = sel_idx;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // controller state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         ttl_ff       <= tkrc_pkg::TTL_RESET;
         rsp_valid_ff <= 1'b0;
         wr_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         ttl_ff       <= ttl_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_ff        <= wr_in;
      end
      hold_ff     <= hold_in;
      fin_ff      <= fin_in;
      fin_live_ff <= fin_live_in;
      fin_inv_ff  <= fin_inv_in;
      fin_min_ff  <= fin_min_in;
      rsp_ff      <= rsp_in;
      wr_idx_ff   <= wr_idx_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
